// File: rtl/core/prefix_code_bit_packer_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the prefix code bit packer
// Shared clocking and reset handling for the concurrent checks in the core.
// ----------------------------------------------------------------------------
`ifndef PREFIX_CODE_BIT_PACKER_TOP_ASSERT_SVH
`define PREFIX_CODE_BIT_PACKER_TOP_ASSERT_SVH

// The condition must never be true at a clock edge outside reset.
`define PCBP_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

// When the first condition holds, the second must hold in the next cycle.
`define PCBP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/pcbp_pkg.sv
// ----------------------------------------------------------------------------
// Prefix code bit packer package
// Widths, operation codes and shared types of the packer core.
// ----------------------------------------------------------------------------
package pcbp_pkg;

	// Table and accumulator sizes.
	localparam int SYMBOL_COUNT = 256;
	localparam int WORD_BITS    = 64;

	// Fixed widths of the item fields.
	localparam int OP_BITS         = 2;
	localparam int SYM_BITS        = 8;
	localparam int CODE_FIELD_BITS = 64;
	localparam int LEN_BITS        = 7;
	localparam int WORD_FIELD_BITS = 64;

	// Derived widths.
	localparam int ADDR_BITS     = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int HELD_BITS     = $clog2(WORD_BITS + 1);
	localparam int IN_DATA_BITS  = ((SYM_BITS + CODE_FIELD_BITS + LEN_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_BITS = ((WORD_FIELD_BITS + 7) / 8) * 8;

	// Output queue depth and its counter width.
	localparam int OUT_DEPTH = 3;
	localparam int PTR_BITS  = $clog2(OUT_DEPTH);
	localparam int CNT_BITS  = $clog2(OUT_DEPTH + 1);

	typedef enum logic [OP_BITS-1:0] {
		OP_LOAD   = 2'd0,
		OP_ENCODE = 2'd1,
		OP_FLUSH  = 2'd2
	} op_t;

	// Control of the item that moves into the packing stage.
	typedef struct packed {
		logic valid;
		op_t  op;
	} stage_ctrl_t;

	// One result item.
	typedef struct packed {
		logic [WORD_BITS-1:0] word;
		logic                 is_final;
	} result_t;

	// Ones in the n lowest bits; all ones when n reaches the word width.
	function automatic logic [WORD_BITS-1:0] low_mask(input logic [HELD_BITS-1:0] n);
		logic [WORD_BITS-1:0] ones;
		ones = '1;
		return ~(ones << n);
	endfunction

endpackage

// File: rtl/core/pcbp_code_table.sv
// ----------------------------------------------------------------------------
// Code table
// Code word and length memories with registered reads. Per-entry
// valid bits make every length read as zero until that entry is loaded.
// ----------------------------------------------------------------------------
module pcbp_code_table (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic                                rd_en,
	input  logic [pcbp_pkg::ADDR_BITS-1:0]      addr,
	input  logic [pcbp_pkg::WORD_BITS-1:0]      wr_code,
	input  logic [pcbp_pkg::HELD_BITS-1:0]      wr_len,
	output logic [pcbp_pkg::WORD_BITS-1:0]      rd_code,
	output logic [pcbp_pkg::HELD_BITS-1:0]      rd_len
);

	logic [pcbp_pkg::WORD_BITS-1:0] code_mem [pcbp_pkg::SYMBOL_COUNT];
	logic [pcbp_pkg::HELD_BITS-1:0] len_mem  [pcbp_pkg::SYMBOL_COUNT];
	logic [pcbp_pkg::SYMBOL_COUNT-1:0] valid_q;

	logic [pcbp_pkg::WORD_BITS-1:0] code_rd_q;
	logic [pcbp_pkg::HELD_BITS-1:0] len_rd_q;
	logic                           vld_rd_q;

	// Memory write and registered read. A load followed at once by an encode
	// of the same symbol sees the new entry, as the write lands at an earlier edge.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			code_mem[addr] <= wr_code;
			len_mem[addr]  <= wr_len;
		end
		if (rd_en) begin
			code_rd_q <= code_mem[addr];
			len_rd_q  <= len_mem[addr];
		end
	end

	// Valid bits, cleared at once by reset, and their registered read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_rd_q <= valid_q[addr];
			end
		end
	end

	// An entry never loaded reads as having no code.
	assign rd_code = code_rd_q;
	assign rd_len  = vld_rd_q ? len_rd_q : '0;

endmodule

// File: rtl/core/pcbp_packer.sv
// ----------------------------------------------------------------------------
// Packing stage
// Holds the bit accumulator and appends the code read from the table, emitting
// a word when the code overflows it, or pads and emits the pending bits on a flush.
// ----------------------------------------------------------------------------
`include "prefix_code_bit_packer_top_assert.svh"

module pcbp_packer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pcbp_pkg::stage_ctrl_t          in_ctrl,
	input  logic [pcbp_pkg::WORD_BITS-1:0] code,
	input  logic [pcbp_pkg::HELD_BITS-1:0] len,
	output logic                           busy,
	output logic                           res_valid,
	output pcbp_pkg::result_t              res
);

	localparam int HB = pcbp_pkg::HELD_BITS;
	localparam int WB = pcbp_pkg::WORD_BITS;

	pcbp_pkg::stage_ctrl_t ctrl_s1;
	logic [WB-1:0]         acc_q;
	logic [HB-1:0]         held_q;

	logic [WB-1:0] acc_n;
	logic [HB-1:0] held_n;
	logic [HB:0]   total;
	logic [HB:0]   over;
	logic [HB-1:0] first;
	logic [HB-1:0] rest;
	logic          fits;
	logic [WB-1:0] head;

	// Stage register and accumulator state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			acc_q   <= '0;
			held_q  <= '0;
		end else begin
			ctrl_s1 <= in_ctrl;
			acc_q   <= acc_n;
			held_q  <= held_n;
		end
	end

	// Bit counts of the append and of the split at the word boundary.
	always_comb begin
		total = {1'b0, held_q} + {1'b0, len};
		over  = total - (HB + 1)'(WB);
		rest  = over[HB-1:0];
		first = HB'(WB) - held_q;
		fits  = total <= (HB + 1)'(WB);
		head  = acc_q << first;
	end

	// Append, emit on overflow, or pad and emit on a flush.
	always_comb begin
		acc_n        = acc_q;
		held_n       = held_q;
		res_valid    = 1'b0;
		res.word     = head | (code >> rest);
		res.is_final = 1'b0;
		case (ctrl_s1.op)
			pcbp_pkg::OP_ENCODE: begin
				if (ctrl_s1.valid && (len != '0)) begin
					if (fits) begin
						acc_n  = (acc_q << len) | code;
						held_n = total[HB-1:0];
					end else begin
						res_valid = 1'b1;
						acc_n     = code & pcbp_pkg::low_mask(rest);
						held_n    = rest;
					end
				end
			end
			pcbp_pkg::OP_FLUSH: begin
				if (ctrl_s1.valid && (held_q != '0)) begin
					res_valid    = 1'b1;
					res.word     = head;
					res.is_final = 1'b1;
					acc_n        = '0;
					held_n       = '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy = ctrl_s1.valid;

	`PCBP_ASSERT_NEVER(held_in_range, held_q > HB'(WB), "bit count beyond word width")
	`PCBP_ASSERT_NEXT(flush_clears, res_valid && res.is_final, held_q == '0, "flush left bits held")

endmodule

// File: rtl/core/pcbp_out_fifo.sv
// ----------------------------------------------------------------------------
// Output queue
// Small register queue that takes result items from the packing stage and
// presents them on the master side.
// ----------------------------------------------------------------------------
`include "prefix_code_bit_packer_top_assert.svh"

module pcbp_out_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  pcbp_pkg::result_t             wr_data,
	input  logic                          rd_en,
	output pcbp_pkg::result_t             rd_data,
	output logic                          not_empty,
	output logic [pcbp_pkg::CNT_BITS-1:0] count
);

	localparam int PB = pcbp_pkg::PTR_BITS;
	localparam int CB = pcbp_pkg::CNT_BITS;

	pcbp_pkg::result_t entry_q [pcbp_pkg::OUT_DEPTH];
	logic [PB-1:0]     wr_ptr_q;
	logic [PB-1:0]     rd_ptr_q;
	logic [CB-1:0]     count_q;

	function automatic logic [PB-1:0] ptr_next(input logic [PB-1:0] p);
		return (p == PB'(pcbp_pkg::OUT_DEPTH - 1)) ? '0 : p + PB'(1);
	endfunction

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (rd_en) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CB'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CB'(1);
			end
		end
	end

	assign rd_data   = entry_q[rd_ptr_q];
	assign not_empty = count_q != '0;
	assign count     = count_q;

	`PCBP_ASSERT_NEVER(no_overflow, wr_en && !rd_en && (count_q == CB'(pcbp_pkg::OUT_DEPTH)), "write to full output queue")
	`PCBP_ASSERT_NEXT(count_up, wr_en && !rd_en, count_q == $past(count_q) + CB'(1), "fill count did not rise")

endmodule

// File: rtl/core/prefix_code_bit_packer_top.sv
// ----------------------------------------------------------------------------
// Prefix code bit packer, top level
// Code table loads, symbol encoding into a packed word stream and flushing.
//
//   Channel   Direction  Handshake            Content
//   s_*       in         s_tvalid / s_tready  operation in tuser; symbol,
//                                             code value and length in tdata
//   m_*       out        m_tvalid / m_tready  packed word in tdata, final in tlast
//
// One item is taken every cycle while s_tready is high. An item reads the code
// table at its accept edge and is packed in the next cycle, where the
// accumulator update loops through the acc_q and held_q registers; a result
// is registered into the output queue at the end of the packing cycle.
// Reset clears the valid bits of the table at once, so there is no clearing
// pass. s_tready drops only when the three-entry output queue together with
// the item in the packing stage could overflow, i.e. while m_tready is held low.
// ----------------------------------------------------------------------------
module prefix_code_bit_packer_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [7:0] symbol, [71:8] code_value, [78:72] code_length, [79] zero
	input  logic [pcbp_pkg::IN_DATA_BITS-1:0]   s_tdata,
	// [1:0] operation
	input  logic [pcbp_pkg::OP_BITS-1:0]        s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [63:0] packed_word
	output logic [pcbp_pkg::OUT_DATA_BITS-1:0]  m_tdata,
	// is_final
	output logic                                m_tlast
);

	localparam int WB = pcbp_pkg::WORD_BITS;
	localparam int HB = pcbp_pkg::HELD_BITS;
	localparam int LB = pcbp_pkg::LEN_BITS;
	localparam int SB = pcbp_pkg::SYM_BITS;
	localparam int CB = pcbp_pkg::CNT_BITS;

	logic                  in_acc;
	pcbp_pkg::op_t         op;
	logic [SB-1:0]         symbol;
	logic [WB-1:0]         code_in;
	logic [LB-1:0]         len_field;
	logic [HB-1:0]         len_sat;
	logic                  in_range;
	logic                  tbl_wr;
	logic                  tbl_rd;
	pcbp_pkg::stage_ctrl_t stage_ctrl;

	logic [WB-1:0]         tbl_code;
	logic [HB-1:0]         tbl_len;
	logic                  busy;
	logic                  res_valid;
	pcbp_pkg::result_t     res;
	pcbp_pkg::result_t     head_item;
	logic                  q_not_empty;
	logic [CB-1:0]         q_count;
	logic [CB:0]           q_load;

	// Field unpacking.
	assign op        = pcbp_pkg::op_t'(s_tuser);
	assign symbol    = s_tdata[SB-1:0];
	assign code_in   = s_tdata[SB +: WB];
	assign len_field = s_tdata[SB + pcbp_pkg::CODE_FIELD_BITS +: LB];

	// Input acceptance: room for the staged item and the new one.
	assign q_load   = {1'b0, q_count} + (CB + 1)'(busy);
	assign s_tready = q_load <= (CB + 1)'(pcbp_pkg::OUT_DEPTH - 1);
	assign in_acc   = s_tvalid && s_tready;

	// Lengths beyond the word width saturate; symbols beyond the table are ignored.
	always_comb begin
		len_sat  = (len_field > LB'(WB)) ? HB'(WB) : HB'(len_field);
		in_range = {1'b0, symbol} < (SB + 1)'(pcbp_pkg::SYMBOL_COUNT);
	end

	assign tbl_wr           = in_acc && (op == pcbp_pkg::OP_LOAD) && in_range;
	assign tbl_rd           = in_acc && (op == pcbp_pkg::OP_ENCODE) && in_range;
	assign stage_ctrl.valid = tbl_rd || (in_acc && (op == pcbp_pkg::OP_FLUSH));
	assign stage_ctrl.op    = op;

	pcbp_code_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (tbl_wr),
		.rd_en   (tbl_rd),
		.addr    (symbol[pcbp_pkg::ADDR_BITS-1:0]),
		.wr_code (code_in & pcbp_pkg::low_mask(len_sat)),
		.wr_len  (len_sat),
		.rd_code (tbl_code),
		.rd_len  (tbl_len)
	);

	pcbp_packer u_packer (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ctrl   (stage_ctrl),
		.code      (tbl_code),
		.len       (tbl_len),
		.busy      (busy),
		.res_valid (res_valid),
		.res       (res)
	);

	pcbp_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (res_valid),
		.wr_data   (res),
		.rd_en     (m_tvalid && m_tready),
		.rd_data   (head_item),
		.not_empty (q_not_empty),
		.count     (q_count)
	);

	// Master side.
	assign m_tvalid = q_not_empty;
	assign m_tdata  = pcbp_pkg::OUT_DATA_BITS'(head_item.word);
	assign m_tlast  = head_item.is_final;

endmodule
